@@ sv/pce_pkg.sv @@
`timescale 1ns / 1ps

package pce_pkg;

  // table geometry and number format
  localparam int MAX_SEGMENTS = 64;
  localparam int DATA_WIDTH   = 32;
  localparam int FRAC_BITS    = 16;
  localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
  localparam int SEG_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 2);
  localparam int ENTRY_W      = 7;
  localparam int CFG_W        = 7;
  localparam int OUT_SEG_W    = 6;

  // action codes of an input item
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t cubic;
    word_t quad;
    word_t lin;
    word_t cst;
  } coef_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COEF_RD,
    ST_EXEC,
    ST_WB,
    ST_OUT
  } state_t;

  // shared unit operations
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MULK,
    OP_MULQ
  } alu_op_t;

  typedef struct packed {
    logic    go;
    alu_op_t op;
  } alu_ctl_t;

  // operand sources
  typedef enum logic [3:0] {
    SRC_X, SRC_BRK, SRC_A, SRC_B, SRC_C, SRC_D, SRC_S, SRC_B2,
    SRC_A3, SRC_JR, SRC_T, SRC_U, SRC_W, SRC_K2, SRC_K3, SRC_K6
  } src_t;

  // destination registers
  typedef enum logic [2:0] {
    DST_S, DST_B2, DST_A3, DST_JR, DST_T, DST_U, DST_W
  } dst_t;

  typedef struct packed {
    alu_op_t op;
    src_t    src_a;
    src_t    src_b;
    dst_t    dst;
  } uop_t;

  localparam int NUM_STEPS = 16;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  function automatic uop_t mk_uop(input alu_op_t op, input src_t sa, input src_t sb,
                                  input dst_t d);
    uop_t u;
    u.op    = op;
    u.src_a = sa;
    u.src_b = sb;
    u.dst   = d;
    return u;
  endfunction

  // program: offset, scaled coefficients, then Horner chains for value,
  // slope and curvature
  function automatic uop_t uop_at(input logic [STEP_W-1:0] i);
    uop_t u;
    unique case (i)
      4'd0:    u = mk_uop(OP_SUB,  SRC_X,  SRC_BRK, DST_S);
      4'd1:    u = mk_uop(OP_MULK, SRC_B,  SRC_K2,  DST_B2);
      4'd2:    u = mk_uop(OP_MULK, SRC_A,  SRC_K3,  DST_A3);
      4'd3:    u = mk_uop(OP_MULK, SRC_A,  SRC_K6,  DST_JR);
      4'd4:    u = mk_uop(OP_MULQ, SRC_A,  SRC_S,   DST_T);
      4'd5:    u = mk_uop(OP_ADD,  SRC_T,  SRC_B,   DST_T);
      4'd6:    u = mk_uop(OP_MULQ, SRC_T,  SRC_S,   DST_T);
      4'd7:    u = mk_uop(OP_ADD,  SRC_T,  SRC_C,   DST_T);
      4'd8:    u = mk_uop(OP_MULQ, SRC_T,  SRC_S,   DST_T);
      4'd9:    u = mk_uop(OP_ADD,  SRC_T,  SRC_D,   DST_T);
      4'd10:   u = mk_uop(OP_MULQ, SRC_A3, SRC_S,   DST_U);
      4'd11:   u = mk_uop(OP_ADD,  SRC_U,  SRC_B2,  DST_U);
      4'd12:   u = mk_uop(OP_MULQ, SRC_U,  SRC_S,   DST_U);
      4'd13:   u = mk_uop(OP_ADD,  SRC_U,  SRC_C,   DST_U);
      4'd14:   u = mk_uop(OP_MULQ, SRC_JR, SRC_S,   DST_W);
      default: u = mk_uop(OP_ADD,  SRC_W,  SRC_B2,  DST_W);
    endcase
    return u;
  endfunction

endpackage

@@ sv/pce_in_if.sv @@
`timescale 1ns / 1ps

interface pce_in_if;
  import pce_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [ENTRY_W-1:0]    entry_index;
  logic signed [DATA_WIDTH-1:0] break_value;
  logic signed [DATA_WIDTH-1:0] coef_cubic;
  logic signed [DATA_WIDTH-1:0] coef_quad;
  logic signed [DATA_WIDTH-1:0] coef_lin;
  logic signed [DATA_WIDTH-1:0] coef_const;
  logic signed [DATA_WIDTH-1:0] query_point;
  logic                  last_query;

  modport source (
    output valid, action, entry_index, break_value, coef_cubic, coef_quad,
           coef_lin, coef_const, query_point, last_query,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, break_value, coef_cubic, coef_quad,
           coef_lin, coef_const, query_point, last_query,
    output ready
  );

endinterface

@@ sv/pce_out_if.sv @@
`timescale 1ns / 1ps

interface pce_out_if;
  import pce_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [DATA_WIDTH-1:0] value;
  logic signed [DATA_WIDTH-1:0] slope;
  logic signed [DATA_WIDTH-1:0] curvature;
  logic signed [DATA_WIDTH-1:0] jerk;
  logic [OUT_SEG_W-1:0]  segment;
  logic                  out_of_range;
  logic                  overflow;
  logic                  last_result;

  modport source (
    output valid, value, slope, curvature, jerk, segment, out_of_range,
           overflow, last_result,
    input  ready
  );

  modport sink (
    input  valid, value, slope, curvature, jerk, segment, out_of_range,
           overflow, last_result,
    output ready
  );

endinterface

@@ sv/pce_alu.sv @@
`timescale 1ns / 1ps

module pce_alu (
  input  logic               clk,
  input  pce_pkg::alu_ctl_t  ctl,
  input  pce_pkg::word_t     opa,
  input  pce_pkg::word_t     opb,
  output pce_pkg::word_t     res,
  output logic               sat
);
  import pce_pkg::*;

  logic signed [PROD_WIDTH-1:0] wa;
  logic signed [PROD_WIDTH-1:0] wb;
  logic signed [PROD_WIDTH-1:0] prod_r;
  logic signed [PROD_WIDTH-1:0] shifted;
  logic                         shift_r;
  logic [PROD_WIDTH-DATA_WIDTH:0] top_bits;
  logic                         in_range;

  // sign-extend operands to the full product width
  assign wa = {{(PROD_WIDTH - DATA_WIDTH){opa[DATA_WIDTH-1]}}, opa};
  assign wb = {{(PROD_WIDTH - DATA_WIDTH){opb[DATA_WIDTH-1]}}, opb};

  // registered stage: exact sum, difference or product
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      unique case (ctl.op)
        OP_ADD:  prod_r <= wa + wb;
        OP_SUB:  prod_r <= wa - wb;
        OP_MULK: prod_r <= wa * wb;
        OP_MULQ: prod_r <= wa * wb;
      endcase
      shift_r <= (ctl.op == OP_MULQ);
    end
  end

  // combinational stage: drop fraction bits (floor) for OP_MULQ only, then saturate
  assign shifted  = shift_r ? (prod_r >>> FRAC_BITS) : prod_r;
  assign top_bits = shifted[PROD_WIDTH-1:DATA_WIDTH-1];
  assign in_range = (&top_bits) || (~|top_bits);
  assign sat      = !in_range;

  always_comb begin
    if (in_range) begin
      res = shifted[DATA_WIDTH-1:0];
    end else if (shifted[PROD_WIDTH-1]) begin
      res = {1'b1, {(DATA_WIDTH - 1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    end
  end

endmodule

@@ sv/piecewise_cubic_evaluator.sv @@
`timescale 1ns / 1ps

// Piecewise cubic evaluator over a loaded table of breaks and coefficients.
// Input channel in_ch: action 0 loads table entry entry_index (break, and
// the four coefficients when the index is below the segment count limit);
// action 1 evaluates query_point. Result channel out_ch carries value,
// slope, curvature, jerk (signed Q16.16, saturated), the segment used, the
// out-of-range and overflow flags and last_result.
// cfg_we/cfg_wdata write num_segments; write it only while the block idles.
// A load item gives no result, and the block stays ready for the next item.
// An evaluate item with n segments scans breaks 0 to n of the break memory
// one entry a cycle, does one coefficient read, then runs 16 operations, each
// an execute and a write-back state, on the shared multiply-add unit, then
// the output load. The block takes no new item until an evaluate item has
// loaded its result into the output register.
// A finished result sits in the output register; if the receiver stalls,
// the next item is still accepted and runs until its own result is ready.
// Reset clears control state and sets num_segments to 1; the table is not
// cleared and every entry that an evaluation reads must have been loaded.
module piecewise_cubic_evaluator (
  input  logic                       clk,
  input  logic                       rst_n,
  pce_in_if.sink                     in_ch,
  pce_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pce_pkg::CFG_W-1:0]  cfg_wdata
);
  import pce_pkg::*;

  // table memories
  word_t brk_mem [0:MAX_SEGMENTS];
  coef_t coef_mem [0:MAX_SEGMENTS-1];
  word_t brk_rd_r;
  coef_t coef_rd_r;
  logic               brk_we, coef_we, brk_re, coef_re;
  logic [IDX_W-1:0]   brk_raddr;

  // sequencer state
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   nseg_r;
  logic [IDX_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               out_valid_r, out_valid_nxt;

  // item working registers
  word_t              x_r, x_nxt;
  logic               last_r, last_nxt;
  word_t              b0_r, b0_nxt;
  word_t              prev_r, prev_nxt;
  word_t              segbrk_r, segbrk_nxt;
  logic [SEG_W-1:0]   seg_r, seg_nxt;
  logic               oor_r, oor_nxt;
  logic               ovf_r, ovf_nxt;
  word_t              s_r, b2_r, a3_r, jr_r, t_r, u_r, w_r;

  // output register
  word_t              o_value_r, o_slope_r, o_curv_r, o_jerk_r;
  logic [OUT_SEG_W-1:0] o_seg_r;
  logic               o_oor_r, o_ovf_r, o_last_r;

  logic               in_ready, in_acc, dst_we, out_load;
  uop_t               uop;
  alu_ctl_t           alu_ctl;
  word_t              opa, opb, alu_res;
  logic               alu_sat;
  word_t              rd_brk;

  assign in_ready    = (state_r == ST_IDLE);
  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;
  assign uop         = uop_at(step_r);
  assign rd_brk      = brk_rd_r;

  // loads write the memories at acceptance
  assign brk_we  = in_acc && (in_ch.action == ACT_LOAD)
                   && (int'(in_ch.entry_index) <= MAX_SEGMENTS);
  assign coef_we = in_acc && (in_ch.action == ACT_LOAD)
                   && (int'(in_ch.entry_index) < MAX_SEGMENTS);

  always_ff @(posedge clk) begin
    if (brk_we) begin
      brk_mem[IDX_W'(in_ch.entry_index)] <= in_ch.break_value;
    end
    if (coef_we) begin
      coef_mem[SEG_W'(in_ch.entry_index)] <= '{cubic: in_ch.coef_cubic,
                                               quad:  in_ch.coef_quad,
                                               lin:   in_ch.coef_lin,
                                               cst:   in_ch.coef_const};
    end
    if (brk_re) begin
      brk_rd_r <= brk_mem[brk_raddr];
    end
    if (coef_re) begin
      coef_rd_r <= coef_mem[seg_r];
    end
  end

  // operand select for the shared unit
  function automatic word_t pick(input src_t src, input word_t x, input word_t brk,
                                 input coef_t cf, input word_t s, input word_t b2,
                                 input word_t a3, input word_t jr, input word_t t,
                                 input word_t u, input word_t w);
    word_t v;
    unique case (src)
      SRC_X:   v = x;
      SRC_BRK: v = brk;
      SRC_A:   v = cf.cubic;
      SRC_B:   v = cf.quad;
      SRC_C:   v = cf.lin;
      SRC_D:   v = cf.cst;
      SRC_S:   v = s;
      SRC_B2:  v = b2;
      SRC_A3:  v = a3;
      SRC_JR:  v = jr;
      SRC_T:   v = t;
      SRC_U:   v = u;
      SRC_W:   v = w;
      SRC_K2:  v = DATA_WIDTH'(2);
      SRC_K3:  v = DATA_WIDTH'(3);
      SRC_K6:  v = DATA_WIDTH'(6);
    endcase
    return v;
  endfunction

  assign opa = pick(uop.src_a, x_r, segbrk_r, coef_rd_r, s_r, b2_r, a3_r, jr_r,
                    t_r, u_r, w_r);
  assign opb = pick(uop.src_b, x_r, segbrk_r, coef_rd_r, s_r, b2_r, a3_r, jr_r,
                    t_r, u_r, w_r);

  pce_alu u_alu (
    .clk (clk),
    .ctl (alu_ctl),
    .opa (opa),
    .opb (opb),
    .res (alu_res),
    .sat (alu_sat)
  );

  // next state and control
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    step_nxt   = step_r;
    x_nxt      = x_r;
    last_nxt   = last_r;
    b0_nxt     = b0_r;
    prev_nxt   = prev_r;
    segbrk_nxt = segbrk_r;
    seg_nxt    = seg_r;
    oor_nxt    = oor_r;
    ovf_nxt    = ovf_r;
    brk_re     = 1'b0;
    brk_raddr  = cnt_r[IDX_W-1:0];
    coef_re    = 1'b0;
    alu_ctl    = '{go: 1'b0, op: uop.op};
    dst_we     = 1'b0;
    out_load   = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_ch.action == ACT_EVAL)) begin
          if (nseg_r == '0) begin
            n_nxt = IDX_W'(1);
          end else if (int'(nseg_r) > MAX_SEGMENTS) begin
            n_nxt = IDX_W'(MAX_SEGMENTS);
          end else begin
            n_nxt = IDX_W'(nseg_r);
          end
          x_nxt     = in_ch.query_point;
          last_nxt  = in_ch.last_query;
          cnt_nxt   = '0;
          oor_nxt   = 1'b0;
          state_nxt = ST_SEARCH;
        end
      end

      ST_SEARCH: begin
        // read breaks 0..n, one a cycle
        if (cnt_r <= CNT_W'(n_r)) begin
          brk_re     = 1'b1;
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        // compare the break read in the previous cycle
        if (rd_vld_r) begin
          if (rd_idx_r < n_r) begin
            prev_nxt = rd_brk;
            if (rd_idx_r == '0) begin
              b0_nxt     = rd_brk;
              seg_nxt    = '0;
              segbrk_nxt = rd_brk;
            end else if (rd_brk <= x_r) begin
              seg_nxt    = rd_idx_r[SEG_W-1:0];
              segbrk_nxt = rd_brk;
            end
          end else begin
            // end break: settle points outside the table
            if (x_r < b0_r) begin
              seg_nxt    = '0;
              segbrk_nxt = b0_r;
              oor_nxt    = 1'b1;
            end else if (x_r > rd_brk) begin
              seg_nxt    = SEG_W'(n_r - IDX_W'(1));
              segbrk_nxt = prev_r;
              oor_nxt    = 1'b1;
            end
            rd_vld_nxt = 1'b0;
            state_nxt  = ST_COEF_RD;
          end
        end
      end

      ST_COEF_RD: begin
        coef_re   = 1'b1;
        step_nxt  = '0;
        ovf_nxt   = 1'b0;
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        alu_ctl.go = 1'b1;
        state_nxt  = ST_WB;
      end

      ST_WB: begin
        dst_we  = 1'b1;
        ovf_nxt = ovf_r || alu_sat;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_OUT;
        end else begin
          step_nxt  = step_r + STEP_W'(1);
          state_nxt = ST_EXEC;
        end
      end

      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      nseg_r      <= CFG_W'(1);
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        nseg_r <= cfg_wdata;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    rd_idx_r <= rd_idx_nxt;
    x_r      <= x_nxt;
    last_r   <= last_nxt;
    b0_r     <= b0_nxt;
    prev_r   <= prev_nxt;
    segbrk_r <= segbrk_nxt;
    seg_r    <= seg_nxt;
    oor_r    <= oor_nxt;
    ovf_r    <= ovf_nxt;
    if (dst_we) begin
      unique case (uop.dst)
        DST_S:  s_r  <= alu_res;
        DST_B2: b2_r <= alu_res;
        DST_A3: a3_r <= alu_res;
        DST_JR: jr_r <= alu_res;
        DST_T:  t_r  <= alu_res;
        DST_U:  u_r  <= alu_res;
        DST_W:  w_r  <= alu_res;
        default: s_r <= s_r;
      endcase
    end
    if (out_load) begin
      o_value_r <= t_r;
      o_slope_r <= u_r;
      o_curv_r  <= w_r;
      o_jerk_r  <= jr_r;
      o_seg_r   <= OUT_SEG_W'(seg_r);
      o_oor_r   <= oor_r;
      o_ovf_r   <= ovf_r;
      o_last_r  <= last_r;
    end
  end

  // result channel
  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = o_value_r;
  assign out_ch.slope        = o_slope_r;
  assign out_ch.curvature    = o_curv_r;
  assign out_ch.jerk         = o_jerk_r;
  assign out_ch.segment      = o_seg_r;
  assign out_ch.out_of_range = o_oor_r;
  assign out_ch.overflow     = o_ovf_r;
  assign out_ch.last_result  = o_last_r;

endmodule

@@ sv/pce_checker.sv @@
`timescale 1ns / 1ps

module pce_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_action,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pce_pkg::DATA_WIDTH-1:0] out_value,
  input logic [pce_pkg::DATA_WIDTH-1:0] out_jerk,
  input logic [pce_pkg::OUT_SEG_W-1:0]  out_segment,
  input logic                          out_overflow
);
  import pce_pkg::*;

  // a stalled item keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value)
      && $stable(out_jerk) && $stable(out_segment) && $stable(out_overflow))
    else $error("result changed while stalled");

  // an evaluate item occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_EVAL) |=> !in_ready)
    else $error("ready right after an evaluate item");

  // a load item leaves the block ready
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_LOAD) |=> in_ready)
    else $error("not ready after a load item");

  // a new result comes with the block ready again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result shown while the block is still busy");

  // unsaturated jerk is six times a coefficient, hence even
  a_jerk_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_overflow |-> !out_jerk[0])
    else $error("odd jerk without overflow");

endmodule

bind piecewise_cubic_evaluator pce_checker u_pce_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_action    (in_ch.action),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.value),
  .out_jerk     (out_ch.jerk),
  .out_segment  (out_ch.segment),
  .out_overflow (out_ch.overflow)
);

@@ tb/pce_checker.sv @@
`timescale 1ns / 1ps

module pce_scoreboard (
  input  logic                      clk,
  input  logic                      rst_n,
  pce_in_if                         in_ch,
  pce_out_if                        out_ch,
  input  logic                      cfg_we,
  input  logic [pce_pkg::CFG_W-1:0] cfg_wdata,
  output int                        fail_count,
  output int                        pending,
  output int                        evals_done,
  output int                        oor_count,
  output int                        sat_count
);
  import pce_pkg::*;

  localparam longint WORD_MAX = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint WORD_MIN = -WORD_MAX - 1;

  typedef struct packed {
    word_t                value;
    word_t                slope;
    word_t                curvature;
    word_t                jerk;
    logic [OUT_SEG_W-1:0] segment;
    logic                 oor;
    logic                 ovf;
    logic                 last;
  } eval_result_t;

  // shadow of the segment table and the segment count register
  word_t            brk_mem   [0:MAX_SEGMENTS];
  word_t            cubic_mem [0:MAX_SEGMENTS-1];
  word_t            quad_mem  [0:MAX_SEGMENTS-1];
  word_t            lin_mem   [0:MAX_SEGMENTS-1];
  word_t            cst_mem   [0:MAX_SEGMENTS-1];
  logic [CFG_W-1:0] seg_cfg;

  eval_result_t awaited[$];
  bit           sat_hit;
  int           mismatches;
  int           n_evals;
  int           n_oor;
  int           n_sat;

  // clamp to the word range, noting any saturation
  function automatic longint fit(input longint v);
    if (v > WORD_MAX) begin
      sat_hit = 1'b1;
      return WORD_MAX;
    end
    if (v < WORD_MIN) begin
      sat_hit = 1'b1;
      return WORD_MIN;
    end
    return v;
  endfunction

  // fixed-point product, floor rounding, then clamp
  function automatic longint mul_q(input longint a, input longint b);
    return fit((a * b) >>> FRAC_BITS);
  endfunction

  function automatic eval_result_t evaluate_point(input word_t x_in, input logic last_in);
    eval_result_t r;
    int           n;
    int           seg;
    logic         oor;
    longint       x, s, a, b, c, d, t, u, w, jr, b2;
    n = seg_cfg;
    if (n < 1) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    x   = x_in;
    seg = 0;
    oor = 1'b0;
    // segment search, later segment wins on a shared break
    if (x < longint'(brk_mem[0])) begin
      oor = 1'b1;
    end else if (x > longint'(brk_mem[n])) begin
      seg = n - 1;
      oor = 1'b1;
    end else begin
      for (int j = 0; j < n; j++)
        if (longint'(brk_mem[j]) <= x) seg = j;
    end
    sat_hit = 1'b0;
    a = cubic_mem[seg];
    b = quad_mem[seg];
    c = lin_mem[seg];
    d = cst_mem[seg];
    s = fit(x - longint'(brk_mem[seg]));
    // horner chains for value, slope and curvature
    t  = fit(mul_q(a, s) + b);
    t  = fit(mul_q(t, s) + c);
    t  = fit(mul_q(t, s) + d);
    b2 = fit(b * 2);
    u  = fit(mul_q(fit(a * 3), s) + b2);
    u  = fit(mul_q(u, s) + c);
    jr = fit(a * 6);
    w  = fit(mul_q(jr, s) + b2);
    r.value     = word_t'(t);
    r.slope     = word_t'(u);
    r.curvature = word_t'(w);
    r.jerk      = word_t'(jr);
    r.segment   = OUT_SEG_W'(seg);
    r.oor       = oor;
    r.ovf       = sat_hit;
    r.last      = last_in;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input longint got, input longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : watch
    eval_result_t want;
    if (!rst_n) begin
      seg_cfg = 1;
      awaited.delete();
    end else begin
      // results first: an item accepted on this edge cannot have finished
      if (out_ch.valid && out_ch.ready) begin
        if (awaited.size() == 0) begin
          report_mismatch("result with nothing pending, value", out_ch.value, 0);
        end else begin
          want = awaited.pop_front();
          compare_field("value", out_ch.value, want.value);
          compare_field("slope", out_ch.slope, want.slope);
          compare_field("curvature", out_ch.curvature, want.curvature);
          compare_field("jerk", out_ch.jerk, want.jerk);
          compare_field("segment", out_ch.segment, want.segment);
          compare_field("out_of_range", out_ch.out_of_range, want.oor);
          compare_field("overflow", out_ch.overflow, want.ovf);
          compare_field("last_result", out_ch.last_result, want.last);
          n_evals++;
          if (want.oor) n_oor++;
          if (want.ovf) n_sat++;
        end
      end
      // accepted items: table writes or new expectations
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.action == ACT_LOAD) begin
          if (in_ch.entry_index <= MAX_SEGMENTS)
            brk_mem[in_ch.entry_index] = in_ch.break_value;
          if (in_ch.entry_index < MAX_SEGMENTS) begin
            cubic_mem[in_ch.entry_index] = in_ch.coef_cubic;
            quad_mem[in_ch.entry_index]  = in_ch.coef_quad;
            lin_mem[in_ch.entry_index]   = in_ch.coef_lin;
            cst_mem[in_ch.entry_index]   = in_ch.coef_const;
          end
        end else begin
          awaited.insert(awaited.size(),
                         evaluate_point(in_ch.query_point, in_ch.last_query));
        end
      end
      if (cfg_we) seg_cfg = cfg_wdata;
    end
    fail_count <= mismatches;
    pending    <= awaited.size();
    evals_done <= n_evals;
    oor_count  <= n_oor;
    sat_count  <= n_sat;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import pce_pkg::*;

  localparam int     ITEM_BUDGET = 1900;
  localparam int     CYCLE_LIMIT = 2_000_000;
  localparam int     IDLE_PCT    = 32;
  localparam int     ONE         = 1 << FRAC_BITS;
  localparam word_t  W_MAX       = 32'sh7FFF_FFFF;
  localparam word_t  W_MIN       = 32'sh8000_0000;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pce_in_if  in_ch ();
  pce_out_if out_ch ();

  int     fail_count;
  int     pending;
  int     evals_done;
  int     oor_count;
  int     sat_count;
  int     cycles;
  int     items_sent;
  int     phases;
  int     active_segs;
  bit     steady;
  longint brk_plan [0:MAX_SEGMENTS];

  piecewise_cubic_evaluator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pce_scoreboard checker_u (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending),
    .evals_done (evals_done),
    .oor_count  (oor_count),
    .sat_count  (sat_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic word_t rand_coef(input int mode);
    case (mode)
      0:       return word_t'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
      1:       return word_t'(int'($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t clamp_word(input longint v);
    if (v > longint'(W_MAX)) return W_MAX;
    if (v < longint'(W_MIN)) return W_MIN;
    return word_t'(v);
  endfunction

  // query points aimed at segments, breaks and beyond both ends, or anywhere
  function automatic word_t pick_point();
    int     r;
    int     j;
    longint lo, hi;
    r = $urandom_range(99);
    if (r < 60) begin
      j  = $urandom_range(0, active_segs - 1);
      lo = brk_plan[j];
      hi = brk_plan[j + 1];
      if (hi < lo) hi = lo;
      return clamp_word(lo + longint'($urandom) % (hi - lo + 1));
    end
    if (r < 75) return clamp_word(brk_plan[$urandom_range(0, active_segs)]);
    if (r < 85) return clamp_word(brk_plan[0] - 1 - $urandom_range(0, 1 << 20));
    if (r < 95) return clamp_word(brk_plan[active_segs] + 1 + $urandom_range(0, 1 << 20));
    return word_t'($urandom);
  endfunction

  task automatic send_item(input logic act, input logic [ENTRY_W-1:0] idx,
                           input word_t brk, input word_t a, input word_t b,
                           input word_t c, input word_t d, input word_t x,
                           input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.entry_index <= idx;
    in_ch.break_value <= brk;
    in_ch.coef_cubic  <= a;
    in_ch.coef_quad   <= b;
    in_ch.coef_lin    <= c;
    in_ch.coef_const  <= d;
    in_ch.query_point <= x;
    in_ch.last_query  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // writes to indexes past the table are dropped by the block
    if (!(act == ACT_LOAD && idx > MAX_SEGMENTS)) items_sent++;
  endtask

  task automatic load_entry(input logic [ENTRY_W-1:0] idx, input word_t brk,
                            input word_t a, input word_t b, input word_t c,
                            input word_t d);
    send_item(ACT_LOAD, idx, brk, a, b, c, d, word_t'($urandom), 1'($urandom));
    if (idx <= MAX_SEGMENTS) brk_plan[idx] = brk;
  endtask

  task automatic eval_point(input word_t x, input logic last);
    send_item(ACT_EVAL, ENTRY_W'($urandom), word_t'($urandom), word_t'($urandom),
              word_t'($urandom), word_t'($urandom), word_t'($urandom), x, last);
  endtask

  // drain, let the block settle, then write the segment count
  task automatic set_segments(input logic [CFG_W-1:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_segs = (v < 1) ? 1 : ((v > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(v));
    phases++;
  endtask

  // ascending breaks for entries 0..n, with the odd shared break
  task automatic load_table(input int coef_mode, input bit wide);
    longint cur;
    cur = longint'($urandom_range(0, 1 << 25)) - (1 << 24);
    for (int e = 0; e <= active_segs; e++) begin
      if (e > 0 && $urandom_range(7) != 0)
        cur += wide ? $urandom_range(1, 1 << 24) : $urandom_range(1, 1 << 17);
      load_entry(ENTRY_W'(e), clamp_word(cur), rand_coef(coef_mode),
                 rand_coef(coef_mode), rand_coef(coef_mode), rand_coef(coef_mode));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] seg_val;
    int               r;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= ACT_LOAD;
    in_ch.entry_index <= '0;
    in_ch.break_value <= '0;
    in_ch.coef_cubic  <= '0;
    in_ch.coef_quad   <= '0;
    in_ch.coef_lin    <= '0;
    in_ch.coef_const  <= '0;
    in_ch.query_point <= '0;
    in_ch.last_query  <= 1'b0;
    steady      = 1'b0;
    active_segs = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one segment after reset: inside, on both breaks, beyond both ends
    load_entry(0, 0, ONE, -2 * ONE, ONE / 2, 3 * ONE);
    load_entry(1, 4 * ONE, rand_coef(2), rand_coef(2), rand_coef(2), rand_coef(2));
    eval_point(3 * ONE / 2, 1'b0);
    eval_point(0, 1'b0);
    eval_point(4 * ONE, 1'b0);
    eval_point(W_MIN, 1'b0);
    eval_point(W_MAX, 1'b1);
    // indexes past the table must leave it alone
    load_entry(7'd127, word_t'($urandom), rand_coef(2), rand_coef(2), rand_coef(2),
               rand_coef(2));
    load_entry(7'd65, word_t'($urandom), rand_coef(2), rand_coef(2), rand_coef(2),
               rand_coef(2));
    eval_point(2 * ONE, 1'b0);
    // top index carries only a break
    load_entry(7'd64, word_t'($urandom), rand_coef(2), rand_coef(2), rand_coef(2),
               rand_coef(2));
    // extreme coefficients and breaks, saturating offset and products
    load_entry(0, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN);
    load_entry(1, W_MAX, 0, 0, 0, 0);
    eval_point(W_MIN, 1'b0);
    eval_point(0, 1'b0);
    eval_point(W_MAX, 1'b1);

    // shared break between two segments
    set_segments(2);
    load_entry(0, 0, ONE, ONE, ONE, ONE);
    load_entry(1, 0, -ONE, 2 * ONE, -3 * ONE, ONE / 4);
    load_entry(2, 2 * ONE, 0, 0, 0, 0);
    eval_point(0, 1'b0);
    eval_point(2 * ONE, 1'b0);
    eval_point(ONE, 1'b0);
    eval_point(-ONE, 1'b1);

    // count of zero behaves as one
    set_segments(0);
    eval_point(0, 1'b0);
    eval_point(ONE, 1'b1);

    // random phases: new count, fresh table, then mostly queries
    while (items_sent < ITEM_BUDGET) begin
      case (phases)
        3:       seg_val = 7'd64;
        4:       seg_val = 7'd127;
        5:       seg_val = 7'd1;
        default: begin
          r = $urandom_range(9);
          if (r == 0)      seg_val = 7'd0;
          else if (r == 1) seg_val = 7'd64;
          else if (r == 2) seg_val = CFG_W'($urandom_range(65, 127));
          else if (r < 6)  seg_val = CFG_W'($urandom_range(1, 64));
          else             seg_val = CFG_W'($urandom_range(1, 8));
        end
      endcase
      set_segments(seg_val);
      steady = (items_sent >= 700 && items_sent < 1000);
      load_table($urandom_range(0, 2), 1'($urandom));
      repeat ($urandom_range(8, 40)) begin
        r = $urandom_range(99);
        if (r < 80)
          eval_point(pick_point(), $urandom_range(7) == 0);
        else if (r < 92)
          load_entry(ENTRY_W'($urandom_range(0, active_segs)), word_t'($urandom),
                     rand_coef(2), rand_coef(1), rand_coef(0), rand_coef(2));
        else
          load_entry(ENTRY_W'($urandom), word_t'($urandom), rand_coef(2),
                     rand_coef(2), rand_coef(2), rand_coef(2));
      end
    end
    steady = 1'b0;

    // drain and let any stray result show up
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("%0d items sent over %0d register settings, %0d evaluations checked",
             items_sent, phases, evals_done);
    $display("%0d evaluations out of range, %0d with saturation", oor_count, sat_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/pce_pkg.sv
sv/pce_in_if.sv
sv/pce_out_if.sv
sv/pce_alu.sv
sv/piecewise_cubic_evaluator.sv
sv/pce_checker.sv
tb/pce_checker.sv
tb/testbench.sv
